FILE: design/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// shared types and constants for the grid shortest-path search unit
// ----------------------------------------------------------------------------
package gsp_pkg;

    localparam int CELL_W = 6;
    localparam int COST_W = 7;
    localparam int PAR_W  = 3;
    localparam int NODE_W = 1 + COST_W + PAR_W;

    localparam logic [COST_W-1:0] COST_INF = 7'd127;
    localparam logic [COST_W-1:0] COST_CAP = 7'd126;
    localparam logic [5:0]        LAST_K   = 6'd62;

    localparam logic [PAR_W-1:0] PAR_NONE  = 3'd0;
    localparam logic [PAR_W-1:0] PAR_ABOVE = 3'd1;
    localparam logic [PAR_W-1:0] PAR_BELOW = 3'd2;
    localparam logic [PAR_W-1:0] PAR_LEFT  = 3'd3;
    localparam logic [PAR_W-1:0] PAR_RIGHT = 3'd4;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEQ,
        S_DEQ_WAIT,
        S_CUR,
        S_NB,
        S_NB_CHK,
        S_PATH_RD,
        S_PATH_CHK,
        S_PATH_END
    } t_state;

    typedef struct packed {
        logic                vis;
        logic [COST_W-1:0]   cost;
        logic [PAR_W-1:0]    par;
    } t_node;

endpackage

FILE: design/gsp_ram.sv
// ----------------------------------------------------------------------------
// gsp_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module gsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/grid_shortest_path_search_unit.sv
// ----------------------------------------------------------------------------
// grid_shortest_path_search_unit
// breadth-first shortest path search over a 4-connected obstacle grid
// ----------------------------------------------------------------------------
// A load item is taken in the idle state, and the unit stays idle. A solve item
// runs a queue-driven search in which each dequeue passes through the dequeue,
// dequeue-wait and current-cell states; an expanded cell then takes a neighbour
// state per direction and a check state per neighbour inside the grid, as the
// node ram has a single read port; the path is then streamed end cell first,
// each result through a read state and a check state. busy stays high for the
// whole solve, and results appear on o_valid for one cycle each and must be
// taken as they come.
module grid_shortest_path_search_unit #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLS    = 8,
    parameter int QUEUE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_operation,
    input  logic [2:0] i_cell_row,
    input  logic [2:0] i_cell_col,
    input  logic       i_blocked,
    input  logic [2:0] i_goal_row,
    input  logic [2:0] i_goal_col,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    output logic       o_valid,
    output logic [2:0] o_path_col,
    output logic [2:0] o_path_row,
    output logic [5:0] o_path_index,
    output logic       o_found,
    output logic       o_last
);

    localparam int QA = $clog2(QUEUE_DEPTH);
    localparam int CELLS = 64;

    gsp_pkg::t_state r_state, n_state;

    logic [3:0]  r_grid_w, r_grid_h;
    logic [QA:0] r_head, n_head, r_tail, n_tail;
    logic [2:0]  r_cur_row, n_cur_row, r_cur_col, n_cur_col;
    logic [6:0]  r_cur_cost, n_cur_cost;
    logic [1:0]  r_dir, n_dir;
    logic [5:0]  r_nb, n_nb;
    logic [CELLS-1:0] r_touched, n_touched, r_obs_vld, n_obs_vld;
    logic        r_node_tch, r_obs_rv;
    logic [2:0]  r_pos_row, n_pos_row, r_pos_col, n_pos_col;
    logic [5:0]  r_k, n_k;
    logic        r_pend_vld, n_pend_vld;
    logic [2:0]  r_pend_row, n_pend_row, r_pend_col, n_pend_col;
    logic [5:0]  r_pend_k, n_pend_k;
    logic        r_out_valid, n_out_valid, r_out_found, n_out_found;
    logic        r_out_last, n_out_last;
    logic [2:0]  r_out_row, n_out_row, r_out_col, n_out_col;
    logic [5:0]  r_out_k, n_out_k;

    logic [3:0]  w_eff, h_eff;
    logic        node_we, obs_we, obs_wdata, q_we, obs_rdata;
    logic [5:0]  node_waddr, node_raddr, obs_waddr, obs_raddr, q_wdata, q_rdata;
    logic [QA-1:0] q_waddr, q_raddr;
    gsp_pkg::t_node node_wdata, node_raw, node_q;
    logic        nb_ok, obs_eff, mv_ok, in_grid;
    logic [2:0]  nb_row, nb_col, mv_row, mv_col;
    logic [7:0]  pc_sum;
    logic [6:0]  pc;
    logic [2:0]  back_par;

    // clamp of the configured dimensions
    always_comb begin
        if (r_grid_w == 4'd0) begin
            w_eff = 4'd1;
        end else if (r_grid_w > 4'(MAX_COLS)) begin
            w_eff = 4'(MAX_COLS);
        end else begin
            w_eff = r_grid_w;
        end
        if (r_grid_h == 4'd0) begin
            h_eff = 4'd1;
        end else if (r_grid_h > 4'(MAX_ROWS)) begin
            h_eff = 4'(MAX_ROWS);
        end else begin
            h_eff = r_grid_h;
        end
    end

    gsp_ram #(.WIDTH(gsp_pkg::NODE_W), .DEPTH(CELLS)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_raw)
    );

    gsp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obs_ram (
        .i_clk   (i_clk),
        .i_we    (obs_we),
        .i_waddr (obs_waddr),
        .i_wdata (obs_wdata),
        .i_raddr (obs_raddr),
        .o_rdata (obs_rdata)
    );

    gsp_ram #(.WIDTH(gsp_pkg::CELL_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    // untouched entries read as cleared
    always_comb begin
        if (r_node_tch) begin
            node_q = node_raw;
        end else begin
            node_q.vis  = 1'b0;
            node_q.cost = gsp_pkg::COST_INF;
            node_q.par  = gsp_pkg::PAR_NONE;
        end
        obs_eff = r_obs_rv & obs_rdata;
    end

    // neighbour of the current cell
    always_comb begin
        nb_row   = r_cur_row;
        nb_col   = r_cur_col;
        nb_ok    = 1'b0;
        back_par = gsp_pkg::PAR_NONE;
        case (r_dir)
            gsp_pkg::DIR_UP: begin
                nb_row   = r_cur_row - 3'd1;
                nb_ok    = (r_cur_row != 3'd0);
                back_par = gsp_pkg::PAR_BELOW;
            end
            gsp_pkg::DIR_DOWN: begin
                nb_row   = r_cur_row + 3'd1;
                nb_ok    = ({1'b0, r_cur_row} + 4'd1) < h_eff;
                back_par = gsp_pkg::PAR_ABOVE;
            end
            gsp_pkg::DIR_LEFT: begin
                nb_col   = r_cur_col - 3'd1;
                nb_ok    = (r_cur_col != 3'd0);
                back_par = gsp_pkg::PAR_RIGHT;
            end
            gsp_pkg::DIR_RIGHT: begin
                nb_col   = r_cur_col + 3'd1;
                nb_ok    = ({1'b0, r_cur_col} + 4'd1) < w_eff;
                back_par = gsp_pkg::PAR_LEFT;
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
        pc_sum = {1'b0, r_cur_cost} + 8'd1;
        pc     = (pc_sum > {1'b0, gsp_pkg::COST_CAP}) ? gsp_pkg::COST_CAP : pc_sum[6:0];
    end

    // parent step on the path walk
    always_comb begin
        mv_row = r_pos_row;
        mv_col = r_pos_col;
        mv_ok  = 1'b0;
        case (node_q.par)
            gsp_pkg::PAR_ABOVE: begin
                mv_row = r_pos_row - 3'd1;
                mv_ok  = (r_pos_row != 3'd0);
            end
            gsp_pkg::PAR_BELOW: begin
                mv_row = r_pos_row + 3'd1;
                mv_ok  = ({1'b0, r_pos_row} + 4'd1) < 4'(MAX_ROWS);
            end
            gsp_pkg::PAR_LEFT: begin
                mv_col = r_pos_col - 3'd1;
                mv_ok  = (r_pos_col != 3'd0);
            end
            gsp_pkg::PAR_RIGHT: begin
                mv_col = r_pos_col + 3'd1;
                mv_ok  = ({1'b0, r_pos_col} + 4'd1) < 4'(MAX_COLS);
            end
            default: begin
                mv_ok = 1'b0;
            end
        endcase
    end

    assign in_grid = ({1'b0, i_cell_row} < h_eff) && ({1'b0, i_cell_col} < w_eff)
                  && ({1'b0, i_goal_row} < h_eff) && ({1'b0, i_goal_col} < w_eff);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gsp_pkg::S_IDLE: begin
                if (start && i_operation == gsp_pkg::OP_SOLVE && in_grid) begin
                    n_state = gsp_pkg::S_DEQ;
                end
            end
            gsp_pkg::S_DEQ: begin
                n_state = (r_head < r_tail) ? gsp_pkg::S_DEQ_WAIT : gsp_pkg::S_PATH_RD;
            end
            gsp_pkg::S_DEQ_WAIT: n_state = gsp_pkg::S_CUR;
            gsp_pkg::S_CUR: begin
                n_state = node_q.vis ? gsp_pkg::S_DEQ : gsp_pkg::S_NB;
            end
            gsp_pkg::S_NB: begin
                if (nb_ok) begin
                    n_state = gsp_pkg::S_NB_CHK;
                end else if (r_dir == gsp_pkg::DIR_RIGHT) begin
                    n_state = gsp_pkg::S_DEQ;
                end
            end
            gsp_pkg::S_NB_CHK: begin
                n_state = (r_dir == gsp_pkg::DIR_RIGHT) ? gsp_pkg::S_DEQ : gsp_pkg::S_NB;
            end
            gsp_pkg::S_PATH_RD: n_state = gsp_pkg::S_PATH_CHK;
            gsp_pkg::S_PATH_CHK: begin
                if (node_q.par == gsp_pkg::PAR_NONE) begin
                    n_state = gsp_pkg::S_IDLE;
                end else if (!mv_ok || r_k == gsp_pkg::LAST_K) begin
                    n_state = gsp_pkg::S_PATH_END;
                end else begin
                    n_state = gsp_pkg::S_PATH_RD;
                end
            end
            gsp_pkg::S_PATH_END: n_state = gsp_pkg::S_IDLE;
            default: n_state = gsp_pkg::S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_cur_cost  = r_cur_cost;
        n_dir       = r_dir;
        n_nb        = r_nb;
        n_touched   = r_touched;
        n_obs_vld   = r_obs_vld;
        n_pos_row   = r_pos_row;
        n_pos_col   = r_pos_col;
        n_k         = r_k;
        n_pend_vld  = r_pend_vld;
        n_pend_row  = r_pend_row;
        n_pend_col  = r_pend_col;
        n_pend_k    = r_pend_k;
        n_out_valid = 1'b0;
        n_out_found = r_out_found;
        n_out_last  = r_out_last;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_k     = r_out_k;
        node_we     = 1'b0;
        node_waddr  = r_nb;
        node_wdata  = node_q;
        node_raddr  = r_nb;
        obs_we      = 1'b0;
        obs_waddr   = {i_cell_row, i_cell_col};
        obs_wdata   = i_blocked;
        obs_raddr   = r_nb;
        q_we        = 1'b0;
        q_waddr     = r_tail[QA-1:0];
        q_wdata     = r_nb;
        q_raddr     = r_head[QA-1:0];
        case (r_state)
            gsp_pkg::S_IDLE: begin
                if (start) begin
                    if (i_operation == gsp_pkg::OP_LOAD) begin
                        if (({1'b0, i_cell_row} < 4'(MAX_ROWS))
                                && ({1'b0, i_cell_col} < 4'(MAX_COLS))) begin
                            obs_we = 1'b1;
                            n_obs_vld[{i_cell_row, i_cell_col}] = 1'b1;
                        end
                    end else if (in_grid) begin
                        n_touched = '0;
                        n_touched[{i_cell_row, i_cell_col}] = 1'b1;
                        node_we         = 1'b1;
                        node_waddr      = {i_cell_row, i_cell_col};
                        node_wdata.vis  = 1'b0;
                        node_wdata.cost = '0;
                        node_wdata.par  = gsp_pkg::PAR_NONE;
                        q_we       = 1'b1;
                        q_waddr    = '0;
                        q_wdata    = {i_cell_row, i_cell_col};
                        n_head     = '0;
                        n_tail     = (QA+1)'(1);
                        n_pos_row  = i_goal_row;
                        n_pos_col  = i_goal_col;
                        n_k        = '0;
                        n_pend_vld = 1'b0;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_found = 1'b0;
                        n_out_last  = 1'b1;
                        n_out_row   = '0;
                        n_out_col   = '0;
                        n_out_k     = '0;
                    end
                end
            end
            gsp_pkg::S_DEQ: begin
                if (r_head < r_tail) begin
                    n_head = r_head + (QA+1)'(1);
                end
            end
            gsp_pkg::S_DEQ_WAIT: begin
                node_raddr = q_rdata;
                n_cur_row  = q_rdata[5:3];
                n_cur_col  = q_rdata[2:0];
            end
            gsp_pkg::S_CUR: begin
                if (!node_q.vis) begin
                    node_we        = 1'b1;
                    node_waddr     = {r_cur_row, r_cur_col};
                    node_wdata.vis = 1'b1;
                    n_touched[{r_cur_row, r_cur_col}] = 1'b1;
                    n_cur_cost = node_q.cost;
                    n_dir      = gsp_pkg::DIR_UP;
                end
            end
            gsp_pkg::S_NB: begin
                node_raddr = {nb_row, nb_col};
                obs_raddr  = {nb_row, nb_col};
                n_nb       = {nb_row, nb_col};
                if (!nb_ok) begin
                    n_dir = r_dir + 2'd1;
                end
            end
            gsp_pkg::S_NB_CHK: begin
                if (!node_q.vis && !obs_eff && r_tail < (QA+1)'(QUEUE_DEPTH)) begin
                    q_we   = 1'b1;
                    n_tail = r_tail + (QA+1)'(1);
                end
                if (pc < node_q.cost) begin
                    node_we         = 1'b1;
                    node_wdata.cost = pc;
                    node_wdata.par  = back_par;
                    n_touched[r_nb] = 1'b1;
                end
                n_dir = r_dir + 2'd1;
            end
            gsp_pkg::S_PATH_RD: begin
                node_raddr = {r_pos_row, r_pos_col};
            end
            gsp_pkg::S_PATH_CHK: begin
                if (node_q.par == gsp_pkg::PAR_NONE) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_found = r_pend_vld;
                    n_out_row   = r_pend_vld ? r_pend_row : 3'd0;
                    n_out_col   = r_pend_vld ? r_pend_col : 3'd0;
                    n_out_k     = r_pend_vld ? r_pend_k : 6'd0;
                end else begin
                    if (r_pend_vld) begin
                        n_out_valid = 1'b1;
                        n_out_last  = 1'b0;
                        n_out_found = 1'b1;
                        n_out_row   = r_pend_row;
                        n_out_col   = r_pend_col;
                        n_out_k     = r_pend_k;
                    end
                    n_pend_vld = 1'b1;
                    n_pend_row = r_pos_row;
                    n_pend_col = r_pos_col;
                    n_pend_k   = r_k;
                    n_pos_row  = mv_row;
                    n_pos_col  = mv_col;
                    n_k        = r_k + 6'd1;
                end
            end
            gsp_pkg::S_PATH_END: begin
                n_out_valid = 1'b1;
                n_out_last  = 1'b1;
                n_out_found = 1'b1;
                n_out_row   = r_pend_row;
                n_out_col   = r_pend_col;
                n_out_k     = r_pend_k;
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gsp_pkg::S_IDLE;
            r_grid_w    <= 4'd8;
            r_grid_h    <= 4'd8;
            r_obs_vld   <= '0;
            r_touched   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
            r_pend_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_obs_vld   <= n_obs_vld;
            r_touched   <= n_touched;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
            r_pend_vld  <= n_pend_vld;
            if (i_cfg_we) begin
                if (i_cfg_idx == gsp_pkg::CFG_WIDTH) begin
                    r_grid_w <= i_cfg_data;
                end else begin
                    r_grid_h <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_row   <= n_cur_row;
        r_cur_col   <= n_cur_col;
        r_cur_cost  <= n_cur_cost;
        r_dir       <= n_dir;
        r_nb        <= n_nb;
        r_pos_row   <= n_pos_row;
        r_pos_col   <= n_pos_col;
        r_k         <= n_k;
        r_pend_row  <= n_pend_row;
        r_pend_col  <= n_pend_col;
        r_pend_k    <= n_pend_k;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_k     <= n_out_k;
        r_node_tch  <= r_touched[node_raddr];
        r_obs_rv    <= r_obs_vld[obs_raddr];
    end

    assign busy         = (r_state != gsp_pkg::S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_path_col   = r_out_col;
    assign o_path_row   = r_out_row;
    assign o_path_index = r_out_k;
    assign o_found      = r_out_found;
    assign o_last       = r_out_last;

`ifndef ASSERT_OFF
    a_notfound_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_last && o_path_index == 6'd0))
        else $error("not-found item without last");
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= r_tail) && (r_tail <= (QA+1)'(QUEUE_DEPTH)))
        else $error("queue pointers out of order");
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_path_index <= gsp_pkg::LAST_K))
        else $error("path index beyond limit");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("last item while still searching");
`endif

endmodule
